// ===== hdl/eia_pkg.sv =====
// shared types and constants of the identifier allocator
// used by eia_free_list, eia_entity_table and entity_id_allocator_with_masks_unit
`default_nettype none

package eia_pkg;

	localparam int ENTITY_COUNT    = 1024;
	localparam int COMPONENT_COUNT = 32;

	localparam int ID_W   = $clog2(ENTITY_COUNT);
	localparam int CNT_W  = $clog2(ENTITY_COUNT + 1);
	localparam int COMP_W = 5;

	typedef logic [ID_W-1:0]            id_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [COMPONENT_COUNT-1:0] mask_t;
	typedef logic [COMP_W-1:0]          comp_t;

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_SET   = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NONE_FREE = 2'd1,
		STATUS_NOT_LIVE  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// free list commands: rd fetches the head entry, pop/push move the pointers
	typedef struct packed {
		logic rd;
		logic pop;
		logic push;
		id_t  push_id;
	} fl_ctrl_t;

	// entity table commands: one read and one write port
	typedef struct packed {
		logic  rd;
		id_t   rd_addr;
		logic  wr;
		id_t   wr_addr;
		logic  wr_live;
		mask_t wr_mask;
	} et_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/entity_id_allocator_with_masks_unit.sv =====
// identifier allocator: an accepted item is registered into the execute stage, and its result is written
// to the output register once the output is free, after the read-modify-write of the entity table memory
// an item is taken only once the previous one has left the execute cycle
// reset (arst_n low) clears control state; afterwards a sweep over all 1024 entries clears the live bits
// and s_axis_tready stays low until it ends
// depends on eia_pkg, eia_free_list and eia_entity_table
`default_nettype none

module entity_id_allocator_with_masks_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // target_entity [9:0], component_index [14:10]
	input  wire logic [1:0]  s_axis_tuser,  // kind [1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // entity_out [9:0], mask_out [41:10]
	output logic [1:0]       m_axis_tuser   // status [1:0]
);

	eia_pkg::state_t state_q;
	eia_pkg::state_t state_nxt;

	eia_pkg::kind_t kind_s1;
	eia_pkg::id_t   ent_s1;
	eia_pkg::comp_t comp_s1;

	eia_pkg::cnt_t live_count_q;
	eia_pkg::cnt_t live_count_nxt;

	logic            out_tvalid_q;
	eia_pkg::status_t out_status_q;
	eia_pkg::id_t    out_ent_q;
	eia_pkg::mask_t  out_mask_q;

	eia_pkg::fl_ctrl_t fl_ctrl;
	eia_pkg::et_ctrl_t et_ctrl;
	eia_pkg::id_t      fl_head_id;
	logic              et_ready;
	logic              et_live;
	eia_pkg::mask_t    et_mask;

	logic             in_fire;
	logic             exec_fire;
	logic             out_free;
	eia_pkg::status_t res_status;
	eia_pkg::id_t     res_ent;
	eia_pkg::mask_t   res_mask;
	eia_pkg::mask_t   comp_bit;

	eia_free_list u_free_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (fl_ctrl),
		.head_id (fl_head_id)
	);

	eia_entity_table u_entity_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (et_ctrl),
		.ready   (et_ready),
		.rd_live (et_live),
		.rd_mask (et_mask)
	);

	assign out_free = !out_tvalid_q || m_axis_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			eia_pkg::S_IDLE: begin
				if (s_axis_tvalid && et_ready) begin
					state_nxt = eia_pkg::S_EXEC;
				end
			end
			eia_pkg::S_EXEC: begin
				if (out_free) begin
					state_nxt = eia_pkg::S_IDLE;
				end
			end
			default: state_nxt = eia_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		exec_fire     = 1'b0;
		unique case (state_q)
			eia_pkg::S_IDLE: s_axis_tready = et_ready;
			eia_pkg::S_EXEC: exec_fire     = out_free;
			default: begin
				s_axis_tready = 1'b0;
				exec_fire     = 1'b0;
			end
		endcase
	end

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign comp_bit = (32'(comp_s1) < eia_pkg::COMPONENT_COUNT) ?
		(eia_pkg::mask_t'(1) << comp_s1) : '0;

	// execute: decide the result and the write-back from the read data
	always_comb begin
		fl_ctrl         = '0;
		fl_ctrl.rd      = in_fire;
		fl_ctrl.push_id = ent_s1;
		et_ctrl         = '0;
		et_ctrl.rd      = in_fire;
		et_ctrl.rd_addr = s_axis_tdata[eia_pkg::ID_W-1:0];
		et_ctrl.wr_addr = ent_s1;
		live_count_nxt  = live_count_q;
		res_status      = eia_pkg::STATUS_OK;
		res_ent         = ent_s1;
		res_mask        = '0;
		if (kind_s1 == eia_pkg::KIND_ALLOC) begin
			if (live_count_q == eia_pkg::cnt_t'(eia_pkg::ENTITY_COUNT)) begin
				res_status = eia_pkg::STATUS_NONE_FREE;
				res_ent    = '0;
			end else begin
				res_ent         = fl_head_id;
				fl_ctrl.pop     = exec_fire;
				et_ctrl.wr      = exec_fire;
				et_ctrl.wr_addr = fl_head_id;
				et_ctrl.wr_live = 1'b1;
				live_count_nxt  = live_count_q + eia_pkg::cnt_t'(1);
			end
		end else if (!et_live) begin
			res_status = eia_pkg::STATUS_NOT_LIVE;
		end else if (kind_s1 == eia_pkg::KIND_FREE) begin
			fl_ctrl.push   = exec_fire;
			et_ctrl.wr     = exec_fire;
			live_count_nxt = live_count_q - eia_pkg::cnt_t'(1);
		end else begin
			res_mask        = (kind_s1 == eia_pkg::KIND_SET) ?
				(et_mask | comp_bit) : (et_mask & ~comp_bit);
			et_ctrl.wr      = exec_fire;
			et_ctrl.wr_live = 1'b1;
			et_ctrl.wr_mask = res_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1 <= eia_pkg::kind_t'(s_axis_tuser);
			ent_s1  <= s_axis_tdata[eia_pkg::ID_W-1:0];
			comp_s1 <= s_axis_tdata[eia_pkg::ID_W +: eia_pkg::COMP_W];
		end
		if (exec_fire) begin
			out_status_q <= res_status;
			out_ent_q    <= res_ent;
			out_mask_q   <= res_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= eia_pkg::S_IDLE;
			live_count_q <= '0;
			out_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (exec_fire) begin
				live_count_q <= live_count_nxt;
				out_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_tvalid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {6'd0, out_mask_q, out_ent_q};

	// the live count never exceeds the number of identifiers
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_count_q <= eia_pkg::cnt_t'(eia_pkg::ENTITY_COUNT))
		else $error("live count above identifier count");

	// one item at a time: nothing is taken in the cycle after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_axis_tready)
		else $error("item accepted while another is in execute");

	// a successful free lowers the live count by one
	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && kind_s1 == eia_pkg::KIND_FREE && et_live
		|=> live_count_q == $past(live_count_q) - eia_pkg::cnt_t'(1))
		else $error("free did not lower the live count");

	// a new result only comes out of the execute cycle
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == eia_pkg::S_EXEC))
		else $error("result raised outside execute");

endmodule

`default_nettype wire

// ===== hdl/eia_free_list.sv =====
// fifo free list of identifiers held in a synchronous memory
// depends on eia_pkg; entries never written since reset read as their own index
`default_nettype none

module eia_free_list (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire eia_pkg::fl_ctrl_t ctrl,
	output eia_pkg::id_t         head_id
);

	eia_pkg::id_t mem [eia_pkg::ENTITY_COUNT];

	eia_pkg::id_t head_q;
	eia_pkg::id_t tail_q;
	logic         wrapped_q;

	eia_pkg::id_t rd_data_s1;
	eia_pkg::id_t rd_idx_s1;
	logic         rd_written_s1;

	function automatic eia_pkg::id_t next_ptr(input eia_pkg::id_t p);
		if (p == eia_pkg::id_t'(eia_pkg::ENTITY_COUNT - 1)) begin
			return '0;
		end
		return p + eia_pkg::id_t'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= ctrl.push_id;
		end
		if (ctrl.rd) begin
			rd_data_s1    <= mem[head_q];
			rd_idx_s1     <= head_q;
			// writes go in tail order from zero, so the fill mark tells which slots hold data
			rd_written_s1 <= wrapped_q || (head_q < tail_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			wrapped_q <= 1'b0;
		end else begin
			if (ctrl.pop) begin
				head_q <= next_ptr(head_q);
			end
			if (ctrl.push) begin
				tail_q <= next_ptr(tail_q);
				if (tail_q == eia_pkg::id_t'(eia_pkg::ENTITY_COUNT - 1)) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	assign head_id = rd_written_s1 ? rd_data_s1 : rd_idx_s1;

endmodule

`default_nettype wire

// ===== hdl/eia_entity_table.sv =====
// live bit and component mask per identifier in one synchronous memory
// depends on eia_pkg; a sweep after reset clears every live bit
`default_nettype none

module eia_entity_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire eia_pkg::et_ctrl_t ctrl,
	output logic                   ready,
	output logic                   rd_live,
	output eia_pkg::mask_t         rd_mask
);

	localparam int WORD_W = eia_pkg::COMPONENT_COUNT + 1;

	logic [WORD_W-1:0] mem [eia_pkg::ENTITY_COUNT];
	logic [WORD_W-1:0] rd_word_s1;

	logic         clearing_q;
	eia_pkg::id_t clr_idx_q;

	logic              wr_en;
	eia_pkg::id_t      wr_addr;
	logic [WORD_W-1:0] wr_word;

	always_comb begin
		if (clearing_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			wr_word = '0;
		end else begin
			wr_en   = ctrl.wr;
			wr_addr = ctrl.wr_addr;
			wr_word = {ctrl.wr_live, ctrl.wr_mask};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (ctrl.rd) begin
			rd_word_s1 <= mem[ctrl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == eia_pkg::id_t'(eia_pkg::ENTITY_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + eia_pkg::id_t'(1);
			end
		end
	end

	assign ready   = !clearing_q;
	assign rd_live = rd_word_s1[WORD_W-1];
	assign rd_mask = rd_word_s1[WORD_W-2:0];

endmodule

`default_nettype wire
